// File: hdl/dclrle_pkg.sv
// Shared types and constants for the code-length run-length encoder.
`timescale 1ns / 1ps
`default_nettype none

package dclrle_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [4:0] SYM_REP        = 5'd16;
    localparam logic [4:0] SYM_ZREP_SHORT = 5'd17;
    localparam logic [4:0] SYM_ZREP_LONG  = 5'd18;

    localparam logic [7:0] MIN_REPEAT    = 8'd3;
    localparam logic [7:0] NZ_CHUNK      = 8'd6;
    localparam logic [7:0] Z_CHUNK_SHORT = 8'd10;
    localparam logic [7:0] Z_CHUNK_LONG  = 8'd138;
    localparam logic [7:0] Z_LONG_MIN    = Z_CHUNK_SHORT + 8'd1;

    localparam logic [6:0] NZ_FULL_EXTRA = 7'(NZ_CHUNK - MIN_REPEAT);
    localparam logic [6:0] Z_FULL_EXTRA  = 7'(Z_CHUNK_LONG - Z_LONG_MIN);

    typedef struct packed {
        logic [4:0] symbol;
        logic [6:0] extra;
    } sym_t;

    // Up to three symbols caused by one code length, in emission order 0..2.
    typedef struct packed {
        logic [1:0]     cnt;
        logic           seq_end;
        sym_t [2:0]     syms;
    } bundle_t;

endpackage

`default_nettype wire

// File: hdl/dclrle_front.sv
// Front end: tracks the open run and turns each code length into a symbol bundle.
`timescale 1ns / 1ps
`default_nettype none

module dclrle_front
    import dclrle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_code_length,
    input  logic        s_seq_last,
    input  logic        queue_full,
    output logic        push,
    output bundle_t     push_bundle
);

    typedef struct packed {
        logic [1:0] n;
        sym_t       s0;
        sym_t       s1;
    } flush_t;

    logic       active_reg, active_next;
    logic [3:0] run_value_reg, run_value_next;
    logic [7:0] pending_reg, pending_next;
    logic       accept;

    // Symbols that close a run of the given value with c pending repeats.
    function automatic flush_t flush_f(input logic act, input logic [3:0] val,
                                       input logic [7:0] c);
        flush_t     f;
        logic [7:0] d3;
        logic [7:0] d11;
        f   = '0;
        d3  = c - MIN_REPEAT;
        d11 = c - Z_LONG_MIN;
        if (act) begin
            if (val != 4'd0) begin
                if (c >= MIN_REPEAT) begin
                    f.n  = 2'd1;
                    f.s0 = '{symbol: SYM_REP, extra: d3[6:0]};
                end else begin
                    f.n  = c[1:0];
                    f.s0 = '{symbol: {1'b0, val}, extra: 7'd0};
                    f.s1 = '{symbol: {1'b0, val}, extra: 7'd0};
                end
            end else begin
                if (c >= Z_LONG_MIN) begin
                    f.n  = 2'd1;
                    f.s0 = '{symbol: SYM_ZREP_LONG, extra: d11[6:0]};
                end else if (c >= MIN_REPEAT) begin
                    f.n  = 2'd1;
                    f.s0 = '{symbol: SYM_ZREP_SHORT, extra: d3[6:0]};
                end else begin
                    f.n  = c[1:0];
                    f.s0 = '0;
                    f.s1 = '0;
                end
            end
        end
        return f;
    endfunction

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        sym_t       lst [0:3];
        logic [1:0] n;
        logic [7:0] inc;
        flush_t     f;
        for (int i = 0; i < 4; i++) begin
            lst[i] = '0;
        end
        n   = 2'd0;
        inc = pending_reg + 8'd1;
        f   = '0;
        active_next    = active_reg;
        run_value_next = run_value_reg;
        pending_next   = pending_reg;

        if (active_reg && s_code_length == run_value_reg) begin
            pending_next = inc;
            if (run_value_reg != 4'd0 && inc >= NZ_CHUNK) begin
                lst[n]       = '{symbol: SYM_REP, extra: NZ_FULL_EXTRA};
                n            = n + 2'd1;
                pending_next = 8'd0;
            end else if (run_value_reg == 4'd0 && inc >= Z_CHUNK_LONG) begin
                lst[n]       = '{symbol: SYM_ZREP_LONG, extra: Z_FULL_EXTRA};
                n            = n + 2'd1;
                pending_next = 8'd0;
            end
        end else begin
            f = flush_f(active_reg, run_value_reg, pending_reg);
            if (f.n != 2'd0) begin
                lst[n] = f.s0;
                n      = n + 2'd1;
            end
            if (f.n > 2'd1) begin
                lst[n] = f.s1;
                n      = n + 2'd1;
            end
            active_next    = 1'b1;
            run_value_next = s_code_length;
            if (s_code_length != 4'd0) begin
                lst[n]       = '{symbol: {1'b0, s_code_length}, extra: 7'd0};
                n            = n + 2'd1;
                pending_next = 8'd0;
            end else begin
                pending_next = 8'd1;
            end
        end

        if (s_seq_last) begin
            f = flush_f(active_next, run_value_next, pending_next);
            if (f.n != 2'd0) begin
                lst[n] = f.s0;
                n      = n + 2'd1;
            end
            if (f.n > 2'd1) begin
                lst[n] = f.s1;
                n      = n + 2'd1;
            end
            active_next  = 1'b0;
            pending_next = 8'd0;
        end

        push_bundle.cnt     = n;
        push_bundle.seq_end = s_seq_last;
        push_bundle.syms[0] = lst[0];
        push_bundle.syms[1] = lst[1];
        push_bundle.syms[2] = lst[2];
        push                = accept && (n != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            run_value_reg <= 4'd0;
            pending_reg   <= 8'd0;
        end else if (accept) begin
            active_reg    <= active_next;
            run_value_reg <= run_value_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dclrle_queue.sv
// Short bundle queue between the front end and the symbol emitter.
`timescale 1ns / 1ps
`default_nettype none

module dclrle_queue
    import dclrle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  bundle_t  push_bundle,
    input  logic     pop,
    output logic     full,
    output logic     empty,
    output bundle_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    bundle_t       mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/dclrle_back.sv
// Back end: walks the head bundle and drives one symbol per transfer.
`timescale 1ns / 1ps
`default_nettype none

module dclrle_back
    import dclrle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        empty,
    input  bundle_t     head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_symbol,
    output logic [6:0]  m_repeat_extra,
    output logic        m_run_last,
    output logic        m_seq_end
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [4:0] symbol_reg;
    logic [6:0] extra_reg;
    logic       run_last_reg, seq_end_reg;
    logic       load, at_end;
    sym_t       cur;

    assign load   = !valid_reg || m_ready;
    assign cur    = head.syms[idx_reg];
    assign at_end = (idx_reg == head.cnt - 2'd1);
    assign pop    = load && !empty && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= !empty;
            if (!empty) begin
                idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            symbol_reg   <= cur.symbol;
            extra_reg    <= cur.extra;
            run_last_reg <= at_end;
            seq_end_reg  <= at_end && head.seq_end;
        end
    end

    assign m_valid        = valid_reg;
    assign m_symbol       = symbol_reg;
    assign m_repeat_extra = extra_reg;
    assign m_run_last     = run_last_reg;
    assign m_seq_end      = seq_end_reg;

endmodule

`default_nettype wire

// File: hdl/deflate_code_length_rle_core.sv
// Top level of the DEFLATE code-length run-length encoder.
//
// Code lengths enter one per cycle on the s_ channel; each produces zero to
// three code-length alphabet symbols (with extra-bit values) on the m_ channel,
// one symbol per cycle while m_ready is high. The front end classifies an item
// in the cycle it is accepted and queues its symbols as one bundle in a
// QUEUE_DEPTH-entry queue; s_ready drops only while that queue is full.
// Sustained input rate is one item per cycle as long as the average symbol count
// per item stays at or below one; items that close runs with two or three symbols
// leave one by one via the single registered output stage draining the queue.
`timescale 1ns / 1ps
`default_nettype none

module deflate_code_length_rle_core
    import dclrle_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_code_length,
    input  logic        s_seq_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_symbol,
    output logic [6:0]  m_repeat_extra,
    output logic        m_run_last,
    output logic        m_seq_end
);

    logic    push, pop, full, empty;
    bundle_t push_bundle, head;

    dclrle_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_length (s_code_length),
        .s_seq_last    (s_seq_last),
        .queue_full    (full),
        .push          (push),
        .push_bundle   (push_bundle)
    );

    dclrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .full        (full),
        .empty       (empty),
        .head        (head)
    );

    dclrle_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .empty          (empty),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_repeat_extra (m_repeat_extra),
        .m_run_last     (m_run_last),
        .m_seq_end      (m_seq_end)
    );

`ifndef SYNTH
    a_seq_end_closes_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_seq_end |-> m_run_last)
        else $error("seq_end without run_last");

    a_literal_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol < SYM_REP) |-> m_repeat_extra == 7'd0)
        else $error("literal symbol with nonzero extra");

    a_symbol_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_symbol <= SYM_ZREP_LONG)
        else $error("symbol out of range");

    a_last_item_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_seq_last |-> push)
        else $error("final code length produced no symbols");
`endif

endmodule

`default_nettype wire

// File: verif/tb_deflate_code_length_rle_core.sv
// Self-checking testbench for the DEFLATE code-length run-length encoder core.
`timescale 1ns / 1ps

module tb_deflate_code_length_rle_core;
    import dclrle_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;

    // One code length waiting to be driven, or a pause marker.
    typedef struct {
        logic [3:0] code_length;
        logic       seq_last;
        bit         pause;
        bit [1:0]   phase;
    } length_item_t;

    typedef struct packed {
        logic [4:0] symbol;
        logic [6:0] extra;
        logic       run_last;
        logic       seq_end;
    } cl_symbol_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [3:0] s_code_length = '0;
    logic       s_seq_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [4:0] m_symbol;
    logic [6:0] m_repeat_extra;
    logic       m_run_last;
    logic       m_seq_end;

    length_item_t length_feed_q[$];
    cl_symbol_t   pending_symbols_q[$];

    int unsigned send_idle_pct [4] = '{0, 54, 0, 17};
    int unsigned recv_stall_pct[4] = '{0, 0, 54, 17};
    bit [1:0]    stim_phase = '0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    // Encoder state mirrored by the testbench.
    logic [3:0] open_value = '0;
    logic [7:0] open_count = '0;
    logic       open_run = 1'b0;

    deflate_code_length_rle_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_length  (s_code_length),
        .s_seq_last     (s_seq_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_repeat_extra (m_repeat_extra),
        .m_run_last     (m_run_last),
        .m_seq_end      (m_seq_end)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic emit_symbol(input logic [4:0] sym, input logic [6:0] extra, inout int n);
        cl_symbol_t s;
        s.symbol   = sym;
        s.extra    = extra;
        s.run_last = 1'b0;
        s.seq_end  = 1'b0;
        pending_symbols_q.insert(pending_symbols_q.size(), s);
        n++;
    endtask

    // Flush whatever the open run still owes.
    task automatic close_open_run(inout int n);
        if (!open_run) return;
        if (open_value != 4'd0) begin
            if (open_count >= MIN_REPEAT)
                emit_symbol(SYM_REP, 7'(open_count - MIN_REPEAT), n);
            else
                for (int i = 0; i < open_count; i++) emit_symbol({1'b0, open_value}, '0, n);
        end else begin
            if (open_count >= Z_LONG_MIN)
                emit_symbol(SYM_ZREP_LONG, 7'(open_count - Z_LONG_MIN), n);
            else if (open_count >= MIN_REPEAT)
                emit_symbol(SYM_ZREP_SHORT, 7'(open_count - MIN_REPEAT), n);
            else
                for (int i = 0; i < open_count; i++) emit_symbol(5'd0, '0, n);
        end
        open_count = '0;
        open_run   = 1'b0;
    endtask

    task automatic encode_code_length(input logic [3:0] len, input logic last);
        int n;
        cl_symbol_t tail;
        n = 0;
        if (open_run && len == open_value) begin
            open_count++;
            // full chunks go out as soon as they fill
            if (open_value != 4'd0 && open_count >= NZ_CHUNK) begin
                emit_symbol(SYM_REP, NZ_FULL_EXTRA, n);
                open_count = '0;
            end else if (open_value == 4'd0 && open_count >= Z_CHUNK_LONG) begin
                emit_symbol(SYM_ZREP_LONG, Z_FULL_EXTRA, n);
                open_count = '0;
            end
        end else begin
            close_open_run(n);
            open_run   = 1'b1;
            open_value = len;
            if (len != 4'd0) begin
                emit_symbol({1'b0, len}, '0, n);
                open_count = '0;
            end else begin
                open_count = 8'd1;
            end
        end
        if (last) close_open_run(n);
        if (n > 0) begin
            tail = pending_symbols_q.pop_back();
            tail.run_last = 1'b1;
            tail.seq_end  = last;
            pending_symbols_q.insert(pending_symbols_q.size(), tail);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic add_run(input logic [3:0] val, input int unsigned len, input bit close,
                           input bit [1:0] ph);
        length_item_t it;
        for (int i = 0; i < len; i++) begin
            it.code_length = val;
            it.seq_last    = close && (i == len - 1);
            it.pause       = 1'b0;
            it.phase       = ph;
            length_feed_q.insert(length_feed_q.size(), it);
        end
    endtask

    task automatic add_pause(input bit [1:0] ph);
        length_item_t it;
        it.code_length = '0;
        it.seq_last    = 1'b0;
        it.pause       = 1'b1;
        it.phase       = ph;
        length_feed_q.insert(length_feed_q.size(), it);
    endtask

    task automatic add_random_sequence(input bit [1:0] ph);
        int unsigned boundary_lens[7] = '{2, 3, 6, 7, 10, 11, 12};
        int unsigned runs;
        int unsigned len;
        int unsigned sel;
        logic [3:0]  val;
        runs = $urandom_range(8, 1);
        for (int r = 0; r < runs; r++) begin
            val = ($urandom_range(99) < 35) ? 4'd0 : 4'($urandom_range(15, 1));
            sel = $urandom_range(99);
            if (sel < 50)      len = $urandom_range(4, 1);
            else if (sel < 78) len = $urandom_range(13, 5);
            else if (sel < 92) len = boundary_lens[$urandom_range(6)];
            else               len = $urandom_range(30, 14);
            add_run(val, len, r == runs - 1, ph);
        end
    endtask

    // Driver: pops the feed queue, holds payload until the transfer completes.
    always @(posedge aclk) begin : drive_lengths
        length_item_t head;
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_code_length <= '0;
            s_seq_last    <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (length_feed_q.size() > 0 && length_feed_q[0].pause) begin
                // hold off until every outstanding symbol has drained
                s_valid <= 1'b0;
                if (!s_valid && pending_symbols_q.size() == 0)
                    void'(length_feed_q.pop_front());
            end else if (length_feed_q.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct[length_feed_q[0].phase]) begin
                head = length_feed_q.pop_front();
                s_valid       <= 1'b1;
                s_code_length <= head.code_length;
                s_seq_last    <= head.seq_last;
                stim_phase    <= head.phase;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= ($urandom_range(99) >= recv_stall_pct[stim_phase]);
    end

    // Monitor: predicts on input transfers, checks output transfers in order.
    always @(posedge aclk) begin : watch_symbols
        cl_symbol_t want;
        if (aresetn) begin
            if (s_valid && s_ready) encode_code_length(s_code_length, s_seq_last);
            if (m_valid && m_ready) begin
                if (pending_symbols_q.size() == 0) begin
                    $display("%0t: unexpected symbol, expected none, actual sym %0d extra %0d",
                             $time, m_symbol, m_repeat_extra);
                    mismatch_cnt++;
                end else begin
                    want = pending_symbols_q.pop_front();
                    check_field("symbol", want.symbol, m_symbol);
                    check_field("repeat_extra", want.extra, m_repeat_extra);
                    check_field("run_last", want.run_last, m_run_last);
                    check_field("seq_end", want.seq_end, m_seq_end);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned phase_start;

        // directed: single-item sequences, literals at both ends, short repeats
        add_run(4'd15, 1, 1'b1, 2'd0);
        add_run(4'd0, 1, 1'b1, 2'd0);
        add_run(4'd3, 4, 1'b1, 2'd0);
        add_run(4'd0, 3, 1'b1, 2'd0);
        // same value across a sequence end must not merge
        add_run(4'd4, 1, 1'b1, 2'd0);
        add_run(4'd4, 1, 1'b1, 2'd0);
        add_run(4'd7, 7, 1'b1, 2'd0);
        add_run(4'd1, 2, 1'b1, 2'd0);
        add_run(4'd9, 1, 1'b0, 2'd0);
        add_run(4'd0, 2, 1'b0, 2'd0);
        add_run(4'd9, 1, 1'b1, 2'd0);

        // one zero run across the long-chunk boundary
        add_run(4'd0, $urandom_range(145, 138), 1'b0, 2'd0);
        add_run(4'd2, 1, 1'b1, 2'd0);

        for (int ph = 0; ph < 4; ph++) begin
            phase_start = length_feed_q.size();
            while (length_feed_q.size() - phase_start < 45) add_random_sequence(2'(ph));
            add_pause(2'(ph));
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (length_feed_q.size() != 0 || s_valid) @(posedge aclk);
        while (pending_symbols_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
